// File: sv/bcpa_pkg.sv
package bcpa_pkg;

    // Default coordinate width and the map extent that reset loads.
    localparam int COORD_BITS_DEF = 23;
    localparam logic [63:0] MAP_RESET_VAL = 64'd8388607;

    // Register indexes of the configuration channel.
    typedef enum logic [1:0] {
        REG_MAP_SIZE_X = 2'd0,
        REG_MAP_SIZE_Y = 2'd1,
        REG_MAP_SIZE_Z = 2'd2
    } reg_index_t;

    // Item kinds carried in tuser.
    localparam logic OP_MOVER    = 1'b0;
    localparam logic OP_OBSTACLE = 1'b1;

    // Control that the top level hands to each axis unit.
    typedef struct packed {
        logic step;   // an item is applied at this clock edge
        logic mover;  // the item loads the mover and seeds the clearances
    } axis_cmd_t;

endpackage

// File: sv/bcpa_axis.sv
module bcpa_axis
    import bcpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  axis_cmd_t                      cmd,
    input  logic [COORD_BITS-1:0]          map_size,
    input  logic [COORD_BITS-1:0]          pos,
    input  logic [COORD_BITS-2:0]          half,
    output logic                           ov,
    input  logic                           ov_b,
    input  logic                           ov_d,
    output logic signed [COORD_BITS+1:0]   fwd_next,
    output logic [COORD_BITS-1:0]          back_next
);

    localparam int W = COORD_BITS + 2;

    logic [COORD_BITS-1:0]   center_reg, center_next;
    logic [COORD_BITS-2:0]   half_reg, half_next;
    logic signed [W-1:0]     fwd_reg;
    logic [COORD_BITS-1:0]   back_reg;

    logic signed [W-1:0] mc, mh, oc, oh, ms;
    logic signed [W-1:0] seed_fwd, seed_back, gap_fwd, gap_back, back_ext;
    logic                update;

    always_comb
    begin
        mc = signed'({2'b00, center_reg});
        mh = signed'({3'b000, half_reg});
        oc = signed'({2'b00, pos});
        oh = signed'({3'b000, half});
        ms = signed'({2'b00, map_size});
        back_ext = signed'({2'b00, back_reg});

        // Touching faces count as overlap.
        ov = ((mc - mh) <= (oc + oh)) && ((mc + mh) >= (oc - oh));

        seed_fwd  = ms - oc - oh;
        seed_back = oc - oh;
        gap_fwd   = oc - oh - mc - mh;
        gap_back  = mc - mh - oc - oh;

        // An obstacle only blocks this axis when it is clear of the mover here
        // and overlaps it on both other axes.
        update = cmd.step && !cmd.mover && !ov && ov_b && ov_d;

        center_next = center_reg;
        half_next   = half_reg;
        fwd_next    = fwd_reg;
        back_next   = back_reg;

        if (cmd.step && cmd.mover)
        begin
            center_next = pos;
            half_next   = half;
            fwd_next    = seed_fwd;
            back_next   = (seed_back < 0) ? '0 : seed_back[COORD_BITS-1:0];
        end
        else if (update)
        begin
            if (oc > mc)
            begin
                if (gap_fwd >= 0 && gap_fwd < fwd_reg)
                begin
                    fwd_next = gap_fwd;
                end
            end
            else if (oc < mc)
            begin
                if (gap_back >= 0 && gap_back < back_ext)
                begin
                    back_next = gap_back[COORD_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            half_reg   <= '0;
            fwd_reg    <= '0;
            back_reg   <= '0;
        end
        else
        begin
            center_reg <= center_next;
            half_reg   <= half_next;
            fwd_reg    <= fwd_next;
            back_reg   <= back_next;
        end
    end

endmodule

// File: sv/box_clearance_per_axis.sv
// An accepted word is held in the input register and applied from there; a word
// with tlast set loads its result into the output register that drives m_tdata.
// Throughput: one word per cycle; s_tready drops only while a finished result
// waits on m_tready and the word in the input register also carries tlast.
// Reset clears the mover box and all clearances to zero and loads each map size
// with its default extent; no result is pending after reset.
module box_clearance_per_axis
    import bcpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // pos_x, pos_y, pos_z, half_x, half_y, half_z, zero fill
    input  logic [((6*COORD_BITS-3+7)/8)*8-1:0]       s_tdata,
    // opcode
    input  logic                                      s_tuser,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // clear_fwd_x, clear_back_x, clear_fwd_y, clear_back_y, clear_fwd_z,
    // clear_back_z, zero fill
    output logic [((6*COORD_BITS+6+7)/8)*8-1:0]       m_tdata,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [1:0]                                cfg_addr,
    input  logic [COORD_BITS-1:0]                     cfg_data
);

    localparam int OUT_BITS = 6 * COORD_BITS + 6;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
    localparam int AXIS_OUT = 2 * COORD_BITS + 2;
    localparam logic [COORD_BITS-1:0] MAP_RESET = COORD_BITS'(MAP_RESET_VAL);

    logic [COORD_BITS-1:0] map_size_reg [3];

    logic                  in_valid_reg;
    logic                  in_op_reg;
    logic                  in_last_reg;
    logic [COORD_BITS-1:0] in_pos_reg [3];
    logic [COORD_BITS-2:0] in_half_reg [3];

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  advance, fire, s_accept;
    axis_cmd_t             cmd;
    logic                  ov [3];
    logic signed [COORD_BITS+1:0] fwd_next [3];
    logic [COORD_BITS-1:0]        back_next [3];
    logic [OUT_BITS-1:0]   result_bits;

    assign cfg_ready = 1'b1;

    // The input register only waits when it holds a result-producing word and
    // the output register is still full.
    assign advance  = !(in_last_reg && out_valid_reg && !m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    assign cmd.step  = fire;
    assign cmd.mover = (in_op_reg == OP_MOVER);

    genvar a;
    generate
        for (a = 0; a < 3; a++)
        begin : g_axis
            bcpa_axis #(.COORD_BITS(COORD_BITS)) u_axis (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .map_size  (map_size_reg[a]),
                .pos       (in_pos_reg[a]),
                .half      (in_half_reg[a]),
                .ov        (ov[a]),
                .ov_b      (ov[(a + 1) % 3]),
                .ov_d      (ov[(a + 2) % 3]),
                .fwd_next  (fwd_next[a]),
                .back_next (back_next[a])
            );

            assign result_bits[a*AXIS_OUT +: COORD_BITS+2] = fwd_next[a];
            assign result_bits[a*AXIS_OUT+COORD_BITS+2 +: COORD_BITS] = back_next[a];
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_size_reg[0] <= MAP_RESET;
            map_size_reg[1] <= MAP_RESET;
            map_size_reg[2] <= MAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                REG_MAP_SIZE_X: map_size_reg[0] <= cfg_data;
                REG_MAP_SIZE_Y: map_size_reg[1] <= cfg_data;
                REG_MAP_SIZE_Z: map_size_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            in_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s_accept)
            begin
                in_valid_reg <= 1'b1;
                in_last_reg  <= s_tlast;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
                in_last_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_op_reg <= s_tuser;
            for (int i = 0; i < 3; i++)
            begin
                in_pos_reg[i]  <= s_tdata[i*COORD_BITS +: COORD_BITS];
                in_half_reg[i] <= s_tdata[3*COORD_BITS + i*(COORD_BITS-1) +: COORD_BITS-1];
            end
        end
        if (fire && in_last_reg)
        begin
            out_data_reg <= result_bits;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_data_reg);

endmodule

// File: sv/bcpa_check.sv
module bcpa_check
    import bcpa_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_tvalid,
    input logic                                  s_tready,
    input logic                                  s_tlast,
    input logic                                  m_tvalid,
    input logic                                  m_tready,
    input logic [((6*COORD_BITS+6+7)/8)*8-1:0]   m_tdata
);

    // A result word that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // Each fresh result must follow an accepted word with tlast set.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a preceding last word");

    // The input side only stalls behind a pending, untaken result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with the output free");

endmodule

bind box_clearance_per_axis bcpa_check #(.COORD_BITS(COORD_BITS)) u_bcpa_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb_box_clearance_per_axis.sv
`timescale 1ns / 100ps

module tb_box_clearance_per_axis;
    import bcpa_pkg::*;

    localparam int CB = 23;
    localparam int HB = CB - 1;
    localparam int FB = CB + 2;
    localparam logic [CB-1:0] COORD_MAX = {CB{1'b1}};
    localparam logic [HB-1:0] HALF_MAX = {HB{1'b1}};

    typedef struct {
        logic op;
        logic [2:0][CB-1:0] pos;
        logic [2:0][HB-1:0] half;
        logic last;
    } box_word_t;

    typedef struct {
        logic [2:0][FB-1:0] fwd;
        logic [2:0][CB-1:0] back;
    } clearance_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [135:0] s_tdata;
    logic s_tuser;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [143:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_addr;
    logic [CB-1:0] cfg_data;

    // Predicted block state.
    logic [CB-1:0] map_extent [3];
    longint mover_c [3];
    longint mover_h [3];
    longint free_fwd [3];
    longint free_back [3];

    clearance_t pending_clearances [$];
    int error_count;
    bit no_idle;
    int stall_left;
    string axis_tag [3] = '{"x", "y", "z"};

    box_clearance_per_axis DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    function automatic box_word_t make_word(input logic op, input longint px, input longint py,
                                            input longint pz, input longint hx, input longint hy,
                                            input longint hz, input int last);
        box_word_t w;
        w.op = op;
        w.pos[0] = px[CB-1:0];
        w.pos[1] = py[CB-1:0];
        w.pos[2] = pz[CB-1:0];
        w.half[0] = hx[HB-1:0];
        w.half[1] = hy[HB-1:0];
        w.half[2] = hz[HB-1:0];
        w.last = (last != 0);
        return w;
    endfunction

    // Applies one accepted word to the predicted state and queues a result on last.
    task automatic apply_box_word(input box_word_t w);
        longint c [3];
        longint h [3];
        longint gap;
        bit ov [3];
        int b;
        int d;
        clearance_t r;
        for (int a = 0; a < 3; a++)
        begin
            c[a] = w.pos[a];
            h[a] = w.half[a];
        end
        if (w.op == OP_MOVER)
        begin
            for (int a = 0; a < 3; a++)
            begin
                mover_c[a] = c[a];
                mover_h[a] = h[a];
                free_fwd[a] = longint'(map_extent[a]) - c[a] - h[a];
                free_back[a] = (c[a] - h[a] < 0) ? 0 : c[a] - h[a];
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
                ov[a] = (mover_c[a] - mover_h[a] <= c[a] + h[a]) &&
                        (mover_c[a] + mover_h[a] >= c[a] - h[a]);
            for (int a = 0; a < 3; a++)
            begin
                b = (a + 1) % 3;
                d = (a + 2) % 3;
                if (!ov[a] && ov[b] && ov[d])
                begin
                    if (c[a] > mover_c[a])
                    begin
                        gap = c[a] - h[a] - mover_c[a] - mover_h[a];
                        if (gap >= 0 && gap < free_fwd[a])
                            free_fwd[a] = gap;
                    end
                    else if (c[a] < mover_c[a])
                    begin
                        gap = mover_c[a] - mover_h[a] - c[a] - h[a];
                        if (gap >= 0 && gap < free_back[a])
                            free_back[a] = gap;
                    end
                end
            end
        end
        if (w.last)
        begin
            for (int a = 0; a < 3; a++)
            begin
                r.fwd[a] = FB'(free_fwd[a]);
                r.back[a] = CB'(free_back[a]);
            end
            pending_clearances.push_back(r);
        end
    endtask

    // Called at a falling edge; returns at a falling edge. tvalid stays high when no
    // gap follows, so back-to-back words need no second assignment in one step.
    task automatic send_word(input box_word_t w);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, w.half, w.pos};
        s_tuser <= w.op;
        s_tlast <= w.last;
        do
            @(posedge clk);
        while (!s_tready);
        apply_box_word(w);
        @(negedge clk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_clearances.size() != 0)
            @(posedge clk);
        // Words without last leave no trace in the queue but may still be in flight.
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    // Returns at a falling edge with valid still high; the caller drops it.
    task automatic write_map_size(input reg_index_t idx, input logic [CB-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        map_extent[idx] = val;
        @(negedge clk);
    endtask

    task automatic set_map(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                           input logic [CB-1:0] sz);
        wait_idle();
        write_map_size(REG_MAP_SIZE_X, sx);
        write_map_size(REG_MAP_SIZE_Y, sy);
        write_map_size(REG_MAP_SIZE_Z, sz);
        cfg_valid <= 1'b0;
    endtask

    function automatic box_word_t rand_mover();
        box_word_t w;
        int r;
        w.op = OP_MOVER;
        w.last = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            r = $urandom_range(0, 99);
            w.pos[a] = (r < 10) ? '0 : (r < 20) ? COORD_MAX : CB'($urandom);
            r = $urandom_range(0, 99);
            w.half[a] = (r < 70) ? HB'($urandom_range(0, 'hFFFF)) :
                        (r < 90) ? HB'($urandom_range(0, 'hFFFFF)) : HB'($urandom);
        end
        return w;
    endfunction

    function automatic box_word_t rand_noise();
        box_word_t w;
        w.op = 1'($urandom_range(0, 1));
        w.last = ($urandom_range(0, 99) < 30);
        for (int a = 0; a < 3; a++)
        begin
            w.pos[a] = CB'($urandom);
            w.half[a] = HB'($urandom);
        end
        return w;
    endfunction

    // An obstacle that overlaps the mover on two axes and sits apart on the third.
    function automatic box_word_t near_obstacle(input box_word_t mv);
        box_word_t w;
        int sep;
        longint span;
        longint v;
        sep = $urandom_range(0, 2);
        w.op = OP_OBSTACLE;
        w.last = 1'b0;
        for (int a = 0; a < 3; a++)
            w.half[a] = HB'($urandom_range(0, 'h3FFF));
        for (int a = 0; a < 3; a++)
        begin
            span = longint'(mv.half[a]) + longint'(w.half[a]);
            if (a == sep)
            begin
                v = span + $urandom_range(1, 'h20000);
                v = $urandom_range(0, 1) ? longint'(mv.pos[a]) + v : longint'(mv.pos[a]) - v;
            end
            else
                v = longint'(mv.pos[a]) + longint'($urandom_range(0, 2 * span)) - span;
            if (v < 0)
                v = 0;
            if (v > longint'(COORD_MAX))
                v = COORD_MAX;
            w.pos[a] = v[CB-1:0];
        end
        return w;
    endfunction

    // Queries: a mover and up to six further words, mostly obstacles near it, with last on the final word.
    task automatic run_queries(input int n_words);
        int sent;
        int n_obs;
        box_word_t mv;
        box_word_t w;
        sent = 0;
        while (sent < n_words)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            mv = rand_mover();
            n_obs = $urandom_range(0, 6);
            mv.last = (n_obs == 0);
            send_word(mv);
            sent++;
            for (int k = 0; k < n_obs; k++)
            begin
                if ($urandom_range(0, 99) < 80)
                    w = near_obstacle(mv);
                else
                    w = rand_noise();
                w.last = (k == n_obs - 1) || ($urandom_range(0, 99) < 10);
                send_word(w);
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_directed_cases();
        localparam longint MC = 'h100000;
        // Obstacle before any mover works against the all-zero reset state.
        send_word(make_word(OP_OBSTACLE, 0, 0, 0, 0, 0, 0, 1));
        send_word(make_word(OP_OBSTACLE, 'h1000, 'h20, 'h20, 'h10, 'h10, 'h10, 1));
        // Mover at the extremes: negative forward room, and clamped backward room.
        send_word(make_word(OP_MOVER, COORD_MAX, COORD_MAX, COORD_MAX,
                            HALF_MAX, HALF_MAX, HALF_MAX, 1));
        send_word(make_word(OP_MOVER, 0, 0, 0, HALF_MAX, HALF_MAX, HALF_MAX, 1));
        send_word(make_word(OP_MOVER, MC, MC, MC, 'h1000, 'h1000, 'h1000, 0));
        // Forward and backward limits on each axis, one unit short of touching below.
        send_word(make_word(OP_OBSTACLE, MC + 'h5000, MC, MC, 'h800, 'h800, 'h800, 0));
        send_word(make_word(OP_OBSTACLE, MC - 'h2001, MC, MC, 'h1000, 'h1000, 'h1000, 1));
        send_word(make_word(OP_OBSTACLE, MC, MC + 'h4000, MC + 'h1800, 'h100, 'h200, 'h900, 0));
        send_word(make_word(OP_OBSTACLE, MC, MC - 'h3000, MC, 'h100, 'h100, 'h100, 0));
        send_word(make_word(OP_OBSTACLE, MC - 'h1800, MC, MC + 'h6000, 'h900, 'h100, 'h100, 0));
        send_word(make_word(OP_OBSTACLE, MC, MC, MC - 'h2400, 'h100, 'h100, 'h100, 1));
        // Touching on the free axis counts as overlap and changes nothing.
        send_word(make_word(OP_OBSTACLE, MC + 'h2000, MC, MC, 'h1000, 'h100, 'h100, 0));
        // Overlap on all three axes, or on only one, is ignored.
        send_word(make_word(OP_OBSTACLE, MC, MC, MC, HALF_MAX, HALF_MAX, HALF_MAX, 0));
        send_word(make_word(OP_OBSTACLE, MC + 'h3000, MC + 'h9000, MC, 'h100, 'h100, 'h100, 1));
        // Farther than the current limit: no change.
        send_word(make_word(OP_OBSTACLE, MC + 'h9000, MC, MC, 'h100, 'h100, 'h100, 1));
        send_word(make_word(OP_MOVER, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
        send_word(make_word(OP_OBSTACLE, 'h10, COORD_MAX, COORD_MAX, 'h8, 0, 0, 0));
        send_word(make_word(OP_OBSTACLE, COORD_MAX, COORD_MAX, 0, 0, 0, 0, 1));
        send_word(make_word(OP_OBSTACLE, COORD_MAX, COORD_MAX, COORD_MAX,
                            HALF_MAX, HALF_MAX, HALF_MAX, 1));
        send_word(make_word(OP_OBSTACLE, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_map_settings();
        set_map('0, '0, '0);
        run_queries(50);
        set_map(COORD_MAX, COORD_MAX, COORD_MAX);
        run_queries(50);
        set_map(COORD_MAX, '0, CB'($urandom));
        run_queries(50);
        set_map(CB'($urandom), CB'($urandom), CB'($urandom_range(0, 'hFFFF)));
        run_queries(50);
    endtask

    task automatic test_random_queries();
        set_map(CB'($urandom), CB'($urandom), CB'($urandom));
        run_queries(200);
    endtask

    task automatic test_noise_words();
        for (int k = 0; k < 50; k++)
            send_word(rand_noise());
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        clearance_t got_c;
        clearance_t exp_c;
        if (rst_n && m_tvalid && m_tready)
        begin
            for (int a = 0; a < 3; a++)
            begin
                got_c.fwd[a] = m_tdata[48*a +: FB];
                got_c.back[a] = m_tdata[48*a+FB +: CB];
            end
            if (pending_clearances.size() == 0)
                report_error("result word with no expected clearances");
            else
            begin
                exp_c = pending_clearances.pop_front();
                for (int a = 0; a < 3; a++)
                begin
                    if (got_c.fwd[a] !== exp_c.fwd[a])
                        report_error($sformatf("clear_fwd_%s got %0d expected %0d", axis_tag[a],
                                               $signed(got_c.fwd[a]), $signed(exp_c.fwd[a])));
                    if (got_c.back[a] !== exp_c.back[a])
                        report_error($sformatf("clear_back_%s got %0d expected %0d",
                                               axis_tag[a], got_c.back[a], exp_c.back[a]));
                end
            end
        end
    end

    // Output back-pressure.
    initial
    begin
        m_tready = 1'b1;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr = '0;
        cfg_data = '0;
        error_count = 0;
        no_idle = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            map_extent[a] = COORD_MAX;
            mover_c[a] = 0;
            mover_h[a] = 0;
            free_fwd[a] = 0;
            free_back[a] = 0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_cases();
        test_map_settings();
        test_random_queries();
        test_noise_words();
        wait_idle();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
